>>> rtl/ssti_pkg.sv
package ssti_pkg;

    localparam int X_W   = 16;
    localparam int Y_W   = 16;
    localparam int ACC_W = 42;
    localparam int INT_W = 41;
    localparam int CNT_OUT_W = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_WHOLE  = 2'd1;
    localparam logic [1:0] CMD_RANGE  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_FEW  = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SRCH_RD,
        OP_SRCH_CMP,
        OP_SH_INIT,
        OP_SH_RD,
        OP_SH_WR,
        OP_INS_WR,
        OP_RD_LAST,
        OP_RD_FIRST,
        OP_SET_SPAN,
        OP_WALK_RD,
        OP_WALK_SEG,
        OP_MUL1,
        OP_MUL2,
        OP_DIV_GO,
        OP_H1,
        OP_H2,
        OP_ACC,
        OP_NEXT,
        OP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_lt_count;
        logic lt;
        logic eq;
        logic full;
        logic few;
        logic idx_eq_pos;
        logic empty;
        logic live;
        logic need1;
        logic need2;
        logic last;
        logic div_busy;
    } t_dp_flags;

endpackage

>>> rtl/ssti_ram.sv
module ssti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/ssti_div.sv
module ssti_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    logic [15:0] r_rem;
    logic [31:0] r_q;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [16:0] rem_sh;
    logic        fits;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_q[31]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? 16'(rem_sh - {1'b0, r_den}) : rem_sh[15:0];
            r_q   <= {r_q[30:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

>>> rtl/ssti_ctrl.sv
module ssti_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_cmd,
    input  ssti_pkg::t_dp_flags i_flags,
    output ssti_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);
    import ssti_pkg::*;

    typedef enum logic [27:0] {
        S_IDLE     = 28'h0000001,
        S_SRCH_CHK = 28'h0000002,
        S_SRCH_RD  = 28'h0000004,
        S_SRCH_CMP = 28'h0000008,
        S_INS_DEC  = 28'h0000010,
        S_SH_CHK   = 28'h0000020,
        S_SH_RD    = 28'h0000040,
        S_SH_WR    = 28'h0000080,
        S_INS_WR   = 28'h0000100,
        S_INT_CHK  = 28'h0000200,
        S_RD_LAST  = 28'h0000400,
        S_RD_FIRST = 28'h0000800,
        S_SET_SPAN = 28'h0001000,
        S_SPAN_CHK = 28'h0002000,
        S_WALK_RD  = 28'h0004000,
        S_WALK_SEG = 28'h0008000,
        S_SEG_CHK  = 28'h0010000,
        S_MUL1     = 28'h0020000,
        S_DIV1     = 28'h0040000,
        S_DIV1_W   = 28'h0080000,
        S_H1       = 28'h0100000,
        S_MUL2     = 28'h0200000,
        S_DIV2     = 28'h0400000,
        S_DIV2_W   = 28'h0800000,
        S_H2       = 28'h1000000,
        S_ACC      = 28'h2000000,
        S_NEXT     = 28'h4000000,
        S_FIN      = 28'h8000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_res, n_res;
    t_dp_op     op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        op      = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    op    = OP_LOAD;
                    n_res = ST_OK;
                    if (i_cmd == CMD_INSERT) begin
                        n_state = S_SRCH_CHK;
                    end else if (i_cmd == CMD_WHOLE || i_cmd == CMD_RANGE) begin
                        n_state = S_INT_CHK;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SRCH_CHK: n_state = i_flags.idx_lt_count ? S_SRCH_RD : S_INS_DEC;
            S_SRCH_RD: begin
                op      = OP_SRCH_RD;
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                op = OP_SRCH_CMP;
                if (i_flags.lt) begin
                    n_state = S_SRCH_CHK;
                end else if (i_flags.eq) begin
                    n_res   = ST_DUP;
                    n_state = S_FIN;
                end else begin
                    n_state = S_INS_DEC;
                end
            end
            S_INS_DEC: begin
                if (i_flags.full) begin
                    n_res   = ST_FULL;
                    n_state = S_FIN;
                end else begin
                    op      = OP_SH_INIT;
                    n_state = S_SH_CHK;
                end
            end
            S_SH_CHK: n_state = i_flags.idx_eq_pos ? S_INS_WR : S_SH_RD;
            S_SH_RD: begin
                op      = OP_SH_RD;
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                op      = OP_SH_WR;
                n_state = S_SH_CHK;
            end
            S_INS_WR: begin
                op      = OP_INS_WR;
                n_state = S_FIN;
            end
            S_INT_CHK: begin
                if (i_flags.few) begin
                    n_res   = ST_FEW;
                    n_state = S_FIN;
                end else begin
                    n_state = S_RD_LAST;
                end
            end
            S_RD_LAST: begin
                op      = OP_RD_LAST;
                n_state = S_RD_FIRST;
            end
            S_RD_FIRST: begin
                op      = OP_RD_FIRST;
                n_state = S_SET_SPAN;
            end
            S_SET_SPAN: begin
                op      = OP_SET_SPAN;
                n_state = S_SPAN_CHK;
            end
            S_SPAN_CHK: n_state = i_flags.empty ? S_FIN : S_WALK_RD;
            S_WALK_RD: begin
                op      = OP_WALK_RD;
                n_state = S_WALK_SEG;
            end
            S_WALK_SEG: begin
                op      = OP_WALK_SEG;
                n_state = S_SEG_CHK;
            end
            S_SEG_CHK: begin
                if (!i_flags.live) begin
                    n_state = S_NEXT;
                end else if (i_flags.need1) begin
                    n_state = S_MUL1;
                end else begin
                    n_state = S_H1;
                end
            end
            S_MUL1: begin
                op      = OP_MUL1;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                op      = OP_DIV_GO;
                n_state = S_DIV1_W;
            end
            S_DIV1_W: n_state = i_flags.div_busy ? S_DIV1_W : S_H1;
            S_H1: begin
                op      = OP_H1;
                n_state = i_flags.need2 ? S_MUL2 : S_H2;
            end
            S_MUL2: begin
                op      = OP_MUL2;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                op      = OP_DIV_GO;
                n_state = S_DIV2_W;
            end
            S_DIV2_W: n_state = i_flags.div_busy ? S_DIV2_W : S_H2;
            S_H2: begin
                op      = OP_H2;
                n_state = S_ACC;
            end
            S_ACC: begin
                op      = OP_ACC;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                op      = OP_NEXT;
                n_state = i_flags.last ? S_FIN : S_WALK_RD;
            end
            S_FIN: begin
                op      = OP_FIN;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.op         = op;
    assign o_cmd.res_status = r_res;
    assign o_busy           = r_state != S_IDLE;
endmodule

>>> rtl/ssti_dp.sv
module ssti_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssti_pkg::t_dp_cmd   i_cmd,
    input  logic [1:0]          i_item_cmd,
    input  logic [15:0]         i_sample_x,
    input  logic signed [15:0]  i_sample_y,
    input  logic [15:0]         i_lower_limit,
    input  logic [15:0]         i_upper_limit,
    output ssti_pkg::t_dp_flags o_flags,
    output logic                o_done,
    output logic [1:0]          o_status,
    output logic signed [40:0]  o_integral,
    output logic [6:0]          o_entry_count
);
    import ssti_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CW-1:0]  r_idx, r_pos, r_count;
    logic [1:0]     r_cmd;
    logic [15:0]    r_sx, r_sy, r_lower, r_upper;
    logic [15:0]    r_last, r_b, r_e, r_lo, r_hi;
    logic           r_empty;
    logic [15:0]    r_prev_x, r_cur_x;
    logic signed [15:0] r_prev_y, r_cur_y;
    logic signed [33:0] r_num;
    logic signed [16:0] r_h1, r_h2;
    logic signed [ACC_W-1:0] r_acc;

    logic [AW-1:0]  raddr, waddr;
    logic           we;
    logic [31:0]    wdata, rdata;
    logic [15:0]    rd_x;
    logic signed [15:0] rd_y;

    logic [15:0]    span_b, span_e, seg_lo, seg_hi, px;
    logic signed [16:0] dy, dxp, qs, h_new;
    logic [31:0]    num_mag, quot;
    logic           div_busy, div_go;
    logic signed [16:0] seg_w;
    logic signed [17:0] hsum;
    logic signed [34:0] prod;

    assign rd_x = rdata[31:16];
    assign rd_y = rdata[15:0];

    always_comb begin
        raddr = r_idx[AW-1:0];
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = rdata;
        case (i_cmd.op)
            OP_SH_RD:    raddr = AW'(r_idx - CW'(1));
            OP_RD_LAST:  raddr = AW'(r_count - CW'(1));
            OP_RD_FIRST: raddr = '0;
            OP_SH_WR:    we = 1'b1;
            OP_INS_WR: begin
                we    = 1'b1;
                waddr = r_pos[AW-1:0];
                wdata = {r_sx, r_sy};
            end
            default: ;
        endcase
    end

    ssti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // clamp the limits to the table's span
    always_comb begin
        if (r_cmd == CMD_RANGE) begin
            span_b = (r_lower > rd_x) ? r_lower : rd_x;
            span_e = (r_upper < r_last) ? r_upper : r_last;
        end else begin
            span_b = rd_x;
            span_e = r_last;
        end
    end

    assign seg_lo = (r_b > r_prev_x) ? r_b : r_prev_x;
    assign seg_hi = (r_e < rd_x) ? r_e : rd_x;

    assign px      = (i_cmd.op == OP_MUL2) ? r_hi : r_lo;
    assign dy      = {r_cur_y[15], r_cur_y} - {r_prev_y[15], r_prev_y};
    assign dxp     = {1'b0, px - r_prev_x};
    assign num_mag = r_num[33] ? 32'(-r_num) : r_num[31:0];
    assign div_go  = i_cmd.op == OP_DIV_GO;

    ssti_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_go),
        .i_num  (num_mag),
        .i_den  (r_cur_x - r_prev_x),
        .o_busy (div_busy),
        .o_quot (quot)
    );

    // truncate toward zero: apply the product's sign to the magnitude quotient
    assign qs    = r_num[33] ? -$signed({1'b0, quot[15:0]}) : $signed({1'b0, quot[15:0]});
    assign h_new = {r_prev_y[15], r_prev_y} + qs;

    assign seg_w = $signed({1'b0, r_hi - r_lo});
    assign hsum  = {r_h1[16], r_h1} + {r_h2[16], r_h2};
    assign prod  = seg_w * hsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= i_cmd.op == OP_FIN;
            case (i_cmd.op)
                OP_LOAD:     r_idx <= '0;
                OP_SRCH_CMP: if (rd_x < r_sx) r_idx <= r_idx + CW'(1);
                OP_SH_INIT:  r_idx <= r_count;
                OP_SH_WR:    r_idx <= r_idx - CW'(1);
                OP_INS_WR:   r_count <= r_count + CW'(1);
                OP_SET_SPAN: r_idx <= CW'(1);
                OP_NEXT:     r_idx <= r_idx + CW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cmd   <= i_item_cmd;
                r_sx    <= i_sample_x;
                r_sy    <= i_sample_y;
                r_lower <= i_lower_limit;
                r_upper <= i_upper_limit;
                r_acc   <= '0;
            end
            OP_SH_INIT:  r_pos <= r_idx;
            OP_RD_FIRST: r_last <= rd_x;
            OP_SET_SPAN: begin
                r_b      <= span_b;
                r_e      <= span_e;
                r_empty  <= (r_cmd == CMD_RANGE && r_upper < r_lower) || span_e <= span_b;
                r_prev_x <= rd_x;
                r_prev_y <= rd_y;
            end
            OP_WALK_SEG: begin
                r_cur_x <= rd_x;
                r_cur_y <= rd_y;
                r_lo    <= seg_lo;
                r_hi    <= seg_hi;
            end
            OP_MUL1, OP_MUL2: r_num <= dy * dxp;
            OP_H1: r_h1 <= (r_lo != r_prev_x) ? h_new : {r_prev_y[15], r_prev_y};
            OP_H2: r_h2 <= (r_hi != r_cur_x) ? h_new : {r_cur_y[15], r_cur_y};
            OP_ACC: r_acc <= r_acc + {{(ACC_W - 35){prod[34]}}, prod};
            OP_NEXT: begin
                r_prev_x <= r_cur_x;
                r_prev_y <= r_cur_y;
            end
            OP_FIN: begin
                o_status      <= i_cmd.res_status;
                o_integral    <= r_acc[ACC_W-1:1];
                o_entry_count <= CNT_OUT_W'(r_count);
            end
            default: ;
        endcase
    end

    assign o_flags.idx_lt_count = r_idx < r_count;
    assign o_flags.lt           = rd_x < r_sx;
    assign o_flags.eq           = rd_x == r_sx;
    assign o_flags.full         = r_count == CW'(TABLE_DEPTH);
    assign o_flags.few          = r_count < CW'(2);
    assign o_flags.idx_eq_pos   = r_idx == r_pos;
    assign o_flags.empty        = r_empty;
    assign o_flags.live         = r_hi > r_lo;
    assign o_flags.need1        = r_lo != r_prev_x;
    assign o_flags.need2        = r_hi != r_cur_x;
    assign o_flags.last         = r_idx == r_count - CW'(1);
    assign o_flags.div_busy     = div_busy;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("sample count beyond table depth");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("index beyond sample count");
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_INS_WR |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not advance count by one");
`endif
endmodule

>>> rtl/sorted_sample_table_integrator.sv
// Between the accepting edge and the result beat, an insert searches the held entries and then
// shifts the entries from the top down to the insert position; integration walks every segment,
// skipping those outside the limits, and waits on the divider for each partial end piece.
// Throughput: one item at a time; busy stays high until the cycle before the result beat.
// Reset: synchronous active-low i_rst_n empties the table; entry contents are not cleared.
// The result beat is held on the ports for one cycle with o_done; the receiver cannot stall.
module sorted_sample_table_integrator #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [15:0]        i_sample_x,
    input  logic signed [15:0] i_sample_y,
    input  logic [15:0]        i_lower_limit,
    input  logic [15:0]        i_upper_limit,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic signed [40:0] o_integral,
    output logic [6:0]         o_entry_count
);
    import ssti_pkg::*;

    t_dp_cmd   dp_cmd;
    t_dp_flags dp_flags;
    logic      ctrl_busy;

    ssti_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_cmd  (i_cmd),
        .i_flags(dp_flags),
        .o_cmd  (dp_cmd),
        .o_busy (ctrl_busy)
    );

    ssti_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_item_cmd   (i_cmd),
        .i_sample_x   (i_sample_x),
        .i_sample_y   (i_sample_y),
        .i_lower_limit(i_lower_limit),
        .i_upper_limit(i_upper_limit),
        .o_flags      (dp_flags),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_integral   (o_integral),
        .o_entry_count(o_entry_count)
    );

    assign busy = ctrl_busy;

`ifndef SYNTHESIS
    a_no_early_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result beat in the cycle after acceptance");
`endif
endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssti_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int DEPTH = 64;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [1:0]  status;
        logic [40:0] integral;
        logic [6:0]  count;
    } table_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_cmd;
    logic [15:0]        i_sample_x;
    logic signed [15:0] i_sample_y;
    logic [15:0]        i_lower_limit;
    logic [15:0]        i_upper_limit;
    logic               o_done;
    logic [1:0]         o_status;
    logic signed [40:0] o_integral;
    logic [6:0]         o_entry_count;

    sorted_sample_table_integrator #(.TABLE_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_sample_x(i_sample_x), .i_sample_y(i_sample_y),
        .i_lower_limit(i_lower_limit), .i_upper_limit(i_upper_limit),
        .o_done(o_done), .o_status(o_status), .o_integral(o_integral),
        .o_entry_count(o_entry_count)
    );

    // predictor state
    logic [15:0]   x_tab [DEPTH];
    int            y_tab [DEPTH];
    int            n_samples;
    table_result_t pending_results [$];
    int            n_mismatch;
    int            idle_cycles;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint height_at(int i, longint px);
        longint x0, x1, y0, y1;
        x0 = x_tab[i];
        x1 = x_tab[i + 1];
        y0 = y_tab[i];
        y1 = y_tab[i + 1];
        return y0 + ((y1 - y0) * (px - x0)) / (x1 - x0);
    endfunction

    function automatic longint trapezoid_sum2(longint b, longint e);
        longint acc, lo, hi, s0, s1;
        acc = 0;
        for (int i = 0; i + 1 < n_samples; i++) begin
            s0 = x_tab[i];
            s1 = x_tab[i + 1];
            lo = (b > s0) ? b : s0;
            hi = (e < s1) ? e : s1;
            if (hi > lo)
                acc += (hi - lo) * (height_at(i, lo) + height_at(i, hi));
        end
        return acc;
    endfunction

    function automatic table_result_t apply_command(logic [1:0] cmd, logic [15:0] sx,
                                                    logic signed [15:0] sy,
                                                    logic [15:0] lower, logic [15:0] upper);
        table_result_t r;
        int pos;
        longint b, e, area;
        logic empty;
        r.status = ST_OK;
        area = 0;
        if (cmd == CMD_INSERT) begin
            pos = 0;
            while (pos < n_samples && x_tab[pos] < sx) pos++;
            if (pos < n_samples && x_tab[pos] == sx) begin
                r.status = ST_DUP;
            end else if (n_samples >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (int k = n_samples; k > pos; k--) begin
                    x_tab[k] = x_tab[k - 1];
                    y_tab[k] = y_tab[k - 1];
                end
                x_tab[pos] = sx;
                y_tab[pos] = sy;
                n_samples++;
            end
        end else if (cmd == CMD_WHOLE || cmd == CMD_RANGE) begin
            if (n_samples < 2) begin
                r.status = ST_FEW;
            end else begin
                b = x_tab[0];
                e = x_tab[n_samples - 1];
                empty = 1'b0;
                if (cmd == CMD_RANGE) begin
                    if (upper < lower) begin
                        empty = 1'b1;
                    end else begin
                        if (lower > b) b = lower;
                        if (upper < e) e = upper;
                        if (e <= b) empty = 1'b1;
                    end
                end
                if (!empty) area = trapezoid_sum2(b, e) >>> 1;
            end
        end
        r.integral = area[40:0];
        r.count = n_samples[6:0];
        return r;
    endfunction

    // one beat, after a random gap; start stays up after acceptance until the next call
    task automatic send_item(logic [1:0] cmd, logic [15:0] sx, logic [15:0] sy,
                             logic [15:0] lower, logic [15:0] upper);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_sample_x <= sx;
        i_sample_y <= sy;
        i_lower_limit <= lower;
        i_upper_limit <= upper;
        do @(posedge i_clk); while (busy);
        pending_results.insert(pending_results.size(),
                               apply_command(cmd, sx, sy, lower, upper));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_item(CMD_WHOLE, 16'h0, 16'h0, 16'h0, 16'hFFFF);
        send_item(CMD_RANGE, 16'h0, 16'h0, 16'h0, 16'hFFFF);
        send_item(CMD_INSERT, 16'h0100, 16'h0200, 16'h0, 16'h0);
        send_item(CMD_WHOLE, 16'h0, 16'h0, 16'h0, 16'h0);
        send_item(CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_extremes();
        send_item(CMD_INSERT, 16'h0000, 16'h8000, 16'h0, 16'h0);
        send_item(CMD_INSERT, 16'hFFFF, 16'h7FFF, 16'h0, 16'h0);
        send_item(CMD_INSERT, 16'h8000, 16'h7FFF, 16'h0, 16'h0);
        send_item(CMD_INSERT, 16'h0000, 16'h1234, 16'h0, 16'h0);
        send_item(CMD_INSERT, 16'hFFFF, 16'h1234, 16'h0, 16'h0);
        send_item(CMD_WHOLE, 16'h0, 16'h0, 16'h0, 16'h0);
        send_item(CMD_RANGE, 16'h0, 16'h0, 16'h0000, 16'hFFFF);
        send_item(CMD_RANGE, 16'h0, 16'h0, 16'h4000, 16'h1000);
        send_item(CMD_RANGE, 16'h0, 16'h0, 16'h2000, 16'h2000);
        send_item(CMD_RANGE, 16'h0, 16'h0, 16'h1235, 16'hC3A1);
        send_item(CMD_RANGE, 16'h0, 16'h0, 16'h8000, 16'h8001);
        send_item(CMD_NOP, 16'h0, 16'h0, 16'h0, 16'h0);
        send_item(CMD_RANGE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();
    endtask

    task automatic test_random_fill(int n_items);
        logic [1:0] cmd;
        logic [15:0] x, lo, hi;
        int pick;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < ((n_samples < DEPTH) ? 40 : 10)) cmd = CMD_INSERT;
            else if (pick < 55) cmd = CMD_WHOLE;
            else if (pick < 97) cmd = CMD_RANGE;
            else cmd = CMD_NOP;
            x = 16'($urandom);
            // land some inserts on present x to hit the duplicate path
            if (n_samples > 0 && $urandom_range(0, 7) == 0)
                x = x_tab[$urandom_range(0, n_samples - 1)];
            lo = 16'($urandom);
            hi = 16'($urandom);
            case ($urandom_range(0, 3))
                0: if (lo > hi) {lo, hi} = {hi, lo};
                1: if (n_samples > 0) begin
                    lo = x_tab[$urandom_range(0, n_samples - 1)];
                    hi = x_tab[$urandom_range(0, n_samples - 1)];
                end
                2: hi = lo + 16'($urandom_range(0, 300));
                default: ;
            endcase
            send_item(cmd, x, 16'($urandom), lo, hi);
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        table_result_t want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected beat: status=%0d integral=%0d count=%0d",
                             o_status, o_integral, o_entry_count);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_integral !== want.integral ||
                    o_entry_count !== want.count) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("beat diff: status %0d/%0d integral %0d/%0d count %0d/%0d",
                                 want.status, o_status, $signed(want.integral), o_integral,
                                 want.count, o_entry_count);
                end
            end
        end
    end

    // watchdog: reset the counter on any accepted beat in or out
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("sorted_sample_table_integrator: mismatch");
                $finish;
            end
        end
    end

    initial begin
        n_samples = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= CMD_INSERT;
        i_sample_x <= '0;
        i_sample_y <= '0;
        i_lower_limit <= '0;
        i_upper_limit <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_extremes();
        test_random_fill(1600);
        if (n_mismatch == 0 && pending_results.size() == 0)
            $display("sorted_sample_table_integrator: match");
        else
            $display("sorted_sample_table_integrator: mismatch");
        $finish;
    end
endmodule

>>> sim.f
rtl/ssti_pkg.sv
rtl/ssti_ram.sv
rtl/ssti_div.sv
rtl/ssti_ctrl.sv
rtl/ssti_dp.sv
rtl/sorted_sample_table_integrator.sv
test/tb.sv
